[src/ete_pkg.sv]
package ete_pkg;

    // Pipeline depth: stage 1 is the offset add, stage NSTG drives the ports.
    localparam int NSTG = 8;

    localparam int EPOCH_W = 32;
    localparam int TZ_W    = 11;
    localparam int TOTAL_W = EPOCH_W + 1;
    localparam int DAYS_W  = 16;
    localparam int SECS_W  = 17;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;

    localparam logic signed [TZ_W-1:0] TZ_MIN = -11'sd720;
    localparam logic signed [TZ_W-1:0] TZ_MAX = 11'sd840;

    // Reciprocals: floor(x / D) == (x * ceil(2^K / D)) >> K for x < 2^N,
    // with K = N + ceil(log2(D)).
    localparam int SH_DAY  = 36;   // x = total >> 7 < 2^26, D = 675
    localparam int SH_HR   = 29;   // x < 2^17, D = 3600
    localparam int SH_MIN  = 18;   // x < 2^12, D = 60
    localparam int SH_1460 = 29;   // x < 2^18, D = 1460
    localparam int SH_365  = 27;   // x < 2^18, D = 365
    localparam int SH_153  = 19;   // x < 2^11, D = 153

    localparam logic [26:0] RCP_675  = 27'(((64'd1 << SH_DAY) + 64'd674) / 64'd675);
    localparam logic [17:0] RCP_3600 = 18'(((64'd1 << SH_HR) + 64'd3599) / 64'd3600);
    localparam logic [12:0] RCP_60   = 13'(((64'd1 << SH_MIN) + 64'd59) / 64'd60);
    localparam logic [18:0] RCP_1460 = 19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RCP_365  = 19'(((64'd1 << SH_365) + 64'd364) / 64'd365);
    localparam logic [11:0] RCP_153  = 12'(((64'd1 << SH_153) + 64'd152) / 64'd153);

    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [19:0]       DAYS_SHIFT    = 20'd719468;
    localparam logic [19:0]       ERA5_START    = 20'd730485;
    localparam logic [19:0]       ERA4_BASE     = 20'd584388;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_stage_en;

    // First day of each March-based month within the year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[src/ete_split.sv]
module ete_split (
    input  logic                              i_clk,
    input  ete_pkg::t_stage_en                i_en,
    input  logic [ete_pkg::EPOCH_W-1:0]       i_epoch,
    input  logic signed [ete_pkg::TZ_W-1:0]   i_tz,
    output logic [ete_pkg::DAYS_W-1:0]        o_days,
    output logic [ete_pkg::HOUR_W-1:0]        o_hour,
    output logic [ete_pkg::MIN_W-1:0]         o_minute
);
    import ete_pkg::*;

    logic signed [16:0]        off60;
    logic signed [33:0]        shifted;
    logic [TOTAL_W-1:0]        n_total;
    logic [TOTAL_W-1:0]        r_total1, r_total2;
    logic [52:0]               day_prod;
    logic [DAYS_W-1:0]         r_days;
    logic [TOTAL_W-1:0]        day_secs;
    logic [SECS_W-1:0]         r_secs3, r_secs4;
    logic [34:0]               hr_prod;
    logic [HOUR_W-1:0]         r_hour4, r_hour5, r_hour6, r_hour7, r_hour8;
    logic [SECS_W-1:0]         hr_secs;
    logic [SECS_W-1:0]         rem_full;
    logic [11:0]               r_rem5;
    logic [24:0]               min_prod;
    logic [MIN_W-1:0]          r_min6, r_min7, r_min8;

    // Stage 1: shift by the offset, clamp below the epoch.
    assign off60   = $signed({{6{i_tz[TZ_W-1]}}, i_tz}) * 17'sd60;
    assign shifted = $signed({2'b00, i_epoch}) + {{17{off60[16]}}, off60};
    assign n_total = shifted[33] ? '0 : shifted[TOTAL_W-1:0];

    // Stage 2: days = total / 86400 as (total >> 7) / 675.
    assign day_prod = 53'(r_total1[TOTAL_W-1:7]) * 53'(RCP_675);

    // Stage 3: seconds of day.
    assign day_secs = TOTAL_W'(r_days) * TOTAL_W'(SECS_PER_DAY);

    // Stage 4: hour, stage 5: remainder, stage 6: minute.
    assign hr_prod  = 35'(r_secs3) * 35'(RCP_3600);
    assign hr_secs  = SECS_W'(r_hour4) * SECS_PER_HOUR;
    assign rem_full = r_secs4 - hr_secs;
    assign min_prod = 25'(r_rem5) * 25'(RCP_60);

    always_ff @(posedge i_clk) begin
        if (i_en.en[0]) r_total1 <= n_total;
        if (i_en.en[1]) begin
            r_total2 <= r_total1;
            r_days   <= day_prod[SH_DAY +: DAYS_W];
        end
        if (i_en.en[2]) r_secs3 <= SECS_W'(r_total2 - day_secs);
        if (i_en.en[3]) begin
            r_secs4 <= r_secs3;
            r_hour4 <= hr_prod[SH_HR +: HOUR_W];
        end
        if (i_en.en[4]) begin
            r_hour5 <= r_hour4;
            r_rem5  <= rem_full[11:0];
        end
        if (i_en.en[5]) begin
            r_hour6 <= r_hour5;
            r_min6  <= min_prod[SH_MIN +: MIN_W];
        end
        if (i_en.en[6]) begin
            r_hour7 <= r_hour6;
            r_min7  <= r_min6;
        end
        if (i_en.en[7]) begin
            r_hour8 <= r_hour7;
            r_min8  <= r_min7;
        end
    end

    assign o_days   = r_days;
    assign o_hour   = r_hour8;
    assign o_minute = r_min8;

endmodule

[src/ete_civil.sv]
module ete_civil (
    input  logic                            i_clk,
    input  ete_pkg::t_stage_en              i_en,
    input  logic [ete_pkg::DAYS_W-1:0]      i_days,
    output logic [ete_pkg::YEAR_W-1:0]      o_year,
    output logic [ete_pkg::MONTH_W-1:0]     o_month,
    output logic [ete_pkg::DAY_W-1:0]       o_day
);
    import ete_pkg::*;

    logic [19:0]   z;
    logic          era5;
    logic [17:0]   doe_n;
    logic          r_era3, r_era4, r_era5, r_era6, r_era7;
    logic [17:0]   r_doe3, r_doe4, r_doe5;
    logic [36:0]   p1460;
    logic [6:0]    q1460;
    logic [2:0]    q36524;
    logic          q146096;
    logic [17:0]   numer;
    logic [17:0]   r_numer4;
    logic [36:0]   p365;
    logic [8:0]    r_yoe5, r_yoe6, r_yoe7;
    logic [1:0]    q100;
    logic [17:0]   yday0;
    logic [17:0]   doy_full;
    logic [8:0]    r_doy6, r_doy7;
    logic [10:0]   mp_arg;
    logic [22:0]   p153;
    logic [3:0]    r_mp7;
    logic          jan_feb;
    logic [11:0]   era_year;
    logic [8:0]    mday;

    // Stage 3: shift to the March-based count from year 0 and split into eras.
    assign z     = 20'(i_days) + DAYS_SHIFT;
    assign era5  = (z >= ERA5_START);
    assign doe_n = 18'(z - ERA4_BASE - (era5 ? 20'd146097 : 20'd0));

    // Stage 4: leap corrections for the year count.
    assign p1460   = 37'(r_doe3) * 37'(RCP_1460);
    assign q1460   = p1460[SH_1460 +: 7];
    assign q36524  = (r_doe3 >= 18'd146096) ? 3'd4 :
                     (r_doe3 >= 18'd109572) ? 3'd3 :
                     (r_doe3 >= 18'd73048)  ? 3'd2 :
                     (r_doe3 >= 18'd36524)  ? 3'd1 : 3'd0;
    assign q146096 = (r_doe3 == 18'd146096);
    assign numer   = r_doe3 - 18'(q1460) + 18'(q36524) - 18'(q146096);

    // Stage 5: year of era.
    assign p365 = 37'(r_numer4) * 37'(RCP_365);

    // Stage 6: day of the March-based year.
    assign q100     = (r_yoe5 >= 9'd300) ? 2'd3 :
                      (r_yoe5 >= 9'd200) ? 2'd2 :
                      (r_yoe5 >= 9'd100) ? 2'd1 : 2'd0;
    assign yday0    = 18'(r_yoe5) * 18'd365 + 18'(r_yoe5[8:2]) - 18'(q100);
    assign doy_full = r_doe5 - yday0;

    // Stage 7: March-based month.
    assign mp_arg = 11'({r_doy6, 2'b00}) + 11'(r_doy6) + 11'd2;
    assign p153   = 23'(mp_arg) * 23'(RCP_153);

    // Stage 8: civil month, day and year.
    assign jan_feb  = (r_mp7 >= 4'd10);
    assign era_year = r_era7 ? 12'd2000 : 12'd1600;
    assign mday     = month_start(r_mp7);

    always_ff @(posedge i_clk) begin
        if (i_en.en[2]) begin
            r_era3 <= era5;
            r_doe3 <= doe_n;
        end
        if (i_en.en[3]) begin
            r_era4   <= r_era3;
            r_doe4   <= r_doe3;
            r_numer4 <= numer;
        end
        if (i_en.en[4]) begin
            r_era5 <= r_era4;
            r_doe5 <= r_doe4;
            r_yoe5 <= p365[SH_365 +: 9];
        end
        if (i_en.en[5]) begin
            r_era6 <= r_era5;
            r_yoe6 <= r_yoe5;
            r_doy6 <= doy_full[8:0];
        end
        if (i_en.en[6]) begin
            r_era7 <= r_era6;
            r_yoe7 <= r_yoe6;
            r_doy7 <= r_doy6;
            r_mp7  <= p153[SH_153 +: 4];
        end
        if (i_en.en[7]) begin
            o_year  <= 12'(r_yoe7) + era_year + 12'(jan_feb);
            o_month <= jan_feb ? r_mp7 - 4'd9 : r_mp7 + 4'd3;
            o_day   <= DAY_W'(r_doy7 - mday + 9'd1);
        end
    end

endmodule

[src/epoch_to_civil_datetime.sv]
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_epoch_seconds
// output    out        o_out_valid / i_out_stall   o_year o_month o_day o_hour o_minute
// config    in         i_cfg_we                    i_cfg_data (signed offset in minutes)
//
// One item per cycle through eight register stages when the output is not stalled.
// The depth is set by the offset add, the day divide and the day-to-civil chain
// (era split, leap corrections, year, day of year, month, final assembly), with at
// most one constant multiply a stage per path.
// Reset (synchronous, active low) empties the pipeline and sets the offset to 0.
// A stall at the output holds the last stage; earlier stages keep moving into
// empty slots, so input stalls only when every stage holds an item.
module epoch_to_civil_datetime (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ete_pkg::EPOCH_W-1:0]        i_epoch_seconds,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ete_pkg::YEAR_W-1:0]         o_year,
    output logic [ete_pkg::MONTH_W-1:0]        o_month,
    output logic [ete_pkg::DAY_W-1:0]          o_day,
    output logic [ete_pkg::HOUR_W-1:0]         o_hour,
    output logic [ete_pkg::MIN_W-1:0]          o_minute,
    input  logic                               i_cfg_we,
    input  logic signed [ete_pkg::TZ_W-1:0]    i_cfg_data
);
    import ete_pkg::*;

    logic signed [TZ_W-1:0] r_tz, n_tz;
    logic [NSTG-1:0]        r_vld;
    t_stage_en              stg;
    logic [DAYS_W-1:0]      days;

    // Clamp the offset on write so the datapath never sees an out-of-range value.
    always_comb begin
        if (i_cfg_data < TZ_MIN) begin
            n_tz = TZ_MIN;
        end else if (i_cfg_data > TZ_MAX) begin
            n_tz = TZ_MAX;
        end else begin
            n_tz = i_cfg_data;
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        stg.en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg.en[k] = !r_vld[k] || stg.en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz  <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_tz <= n_tz;
            if (stg.en[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stg.en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_stall  = !stg.en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // Offset, day split and time of day.
    ete_split u_split (
        .i_clk    (i_clk),
        .i_en     (stg),
        .i_epoch  (i_epoch_seconds),
        .i_tz     (r_tz),
        .o_days   (days),
        .o_hour   (o_hour),
        .o_minute (o_minute)
    );

    // Day count to year, month and day.
    ete_civil u_civil (
        .i_clk   (i_clk),
        .i_en    (stg),
        .i_days  (days),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    // Input stalls only when the whole pipeline is full and the output is held.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1
                         && o_hour <= 5'd23 && o_minute <= 6'd59
                         && o_year >= 12'd1970 && o_year <= 12'd2106))
        else $error("result field out of range");

    a_tz_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_tz >= TZ_MIN && r_tz <= TZ_MAX))
        else $error("offset register outside its limits");

endmodule

[tb/sv/tb_epoch_to_civil_datetime.sv]
module tb_epoch_to_civil_datetime;

    timeunit 1ns;
    timeprecision 1ps;

    import ete_pkg::*;

    // Long enough to cover every phase several times over, even with the
    // worst idle and stall mix and the long output hold-off.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 55;
    localparam int N_PHASES     = 8;
    localparam int MAX_REPORTS  = 10;

    // One civil date and time, laid out like the result ports.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
    } t_civil;

    // Holds the offset copy, turns each accepted timestamp into the date and
    // time it must produce, and matches results in arrival order.
    class civil_scoreboard;
        t_civil                 civil_q[$];
        logic signed [TZ_W-1:0] tz_minutes;
        int                     mismatches;
        int                     results_seen;

        function new();
            tz_minutes   = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_offset(logic signed [TZ_W-1:0] v);
            tz_minutes = v;
        endfunction

        function t_civil to_civil(logic [EPOCH_W-1:0] epoch);
            longint off, total, days, secs, z, era, doe, yoe, yr, doy, mp, d, m;
            t_civil r;
            off = longint'(tz_minutes);
            // Clamp the offset to UTC-12 .. UTC+14.
            if (off < -720) off = -720;
            if (off > 840) off = 840;
            // Keep the sum at full width; clamp local time before the epoch.
            total = longint'({32'd0, epoch}) + off * 60;
            if (total < 0) total = 0;
            days = total / 86400;
            secs = total % 86400;
            // Split into 400-year eras, then year and day within the era.
            z    = days + 719468;
            era  = z / 146097;
            doe  = z - era * 146097;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            yr   = yoe + era * 400;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            // Months count from March; January and February close the year.
            mp   = (5 * doy + 2) / 153;
            d    = doy - (153 * mp + 2) / 5 + 1;
            m    = (mp < 10) ? mp + 3 : mp - 9;
            if (m <= 2) yr = yr + 1;
            r.year   = YEAR_W'(yr);
            r.month  = MONTH_W'(m);
            r.day    = DAY_W'(d);
            r.hour   = HOUR_W'(secs / 3600);
            r.minute = MIN_W'((secs % 3600) / 60);
            return r;
        endfunction

        function void note_epoch(logic [EPOCH_W-1:0] epoch);
            civil_q.push_back(to_civil(epoch));
        endfunction

        function void check_result(t_civil got);
            t_civil want;
            results_seen++;
            if (civil_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d-%0d-%0d %0d:%0d",
                             got.year, got.month, got.day, got.hour, got.minute);
                return;
            end
            want = civil_q.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.hour !== want.hour ||
                got.minute !== want.minute) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected %0d-%0d-%0d %0d:%0d got %0d-%0d-%0d %0d:%0d",
                             want.year, want.month, want.day, want.hour, want.minute,
                             got.year, got.month, got.day, got.hour, got.minute);
            end
        endfunction

        function int outstanding();
            return civil_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [EPOCH_W-1:0]     i_epoch_seconds;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [YEAR_W-1:0]      o_year;
    logic [MONTH_W-1:0]     o_month;
    logic [DAY_W-1:0]       o_day;
    logic [HOUR_W-1:0]      o_hour;
    logic [MIN_W-1:0]       o_minute;
    logic                   i_cfg_we;
    logic signed [TZ_W-1:0] i_cfg_data;

    civil_scoreboard sb;
    t_civil          got_civil;
    int              cycles;
    int              items_in;
    int              settings_used;
    int              idle_pct;
    int              stall_pct;
    bit              hold_req;
    int              hold_left;

    // Timestamps around minute, hour and day edges, leap days, century
    // years and the top of the 32-bit range, all seen with a zero offset.
    logic [EPOCH_W-1:0] utc_edges [16] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd68169600, 32'd946684799, 32'd951782400, 32'd951868799,
        32'd951868800, 32'd4107456000, 32'd4107542400,
        32'h7FFF_FFFF, 32'hFFFF_FFFF
    };

    // Offsets for the random phases: both clamp limits, raw values past
    // them (every register bit at 0 and at 1), and everyday offsets.
    logic signed [TZ_W-1:0] phase_offsets [N_PHASES] = '{
        -11'sd720, 11'sd840, -11'sd1024, 11'sd1023,
        11'sd330, -11'sd1, 11'sd0, -11'sd300
    };

    epoch_to_civil_datetime dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Count cycles; end the run if it hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.outstanding());
            $display("tb_epoch_to_civil_datetime: errors");
            $finish;
        end
    end

    // Sample every handshake at the rising edge. Track register writes first
    // so the offset copy is current for any item taken after the write.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_offset(i_cfg_data);
            if (o_out_valid && !i_out_stall) begin
                got_civil = {o_year, o_month, o_day, o_hour, o_minute};
                sb.check_result(got_civil);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_epoch(i_epoch_seconds);
                items_in++;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request.
    // Count the hold-off here, one stall update per falling edge.
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one item, idling first at random; hold it until it is taken.
    // Call and return at a falling edge.
    task automatic send_epoch(input logic [EPOCH_W-1:0] epoch);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= epoch;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come back,
    // then let the pipeline settle before anything touches the register.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (NSTG + 2) @(negedge i_clk);
    endtask

    // Write the offset register; call only with the pipeline empty.
    task automatic write_offset(input logic signed [TZ_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Draw a timestamp: full-range most often, plus runs near the epoch, near
    // the top of the range and right at day boundaries.
    function automatic logic [EPOCH_W-1:0] pick_epoch();
        logic [EPOCH_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 100000);
            4:       v = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            5:       v = $urandom_range(0, 49710) * 32'd86400;
            6:       v = $urandom_range(1, 49710) * 32'd86400 - $urandom_range(1, 60);
            default: v = $urandom_range(0, 49710) * 32'd86400 + $urandom_range(0, 3660);
        endcase
        return v;
    endfunction

    initial begin
        sb              = new();
        cycles          = 0;
        items_in        = 0;
        settings_used   = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_req        = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_epoch_seconds = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;

        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed edges with the reset offset of zero, back to back.
        foreach (utc_edges[k])
            send_epoch(utc_edges[k]);
        drain_pipeline();

        // Local time before the epoch clamps to midnight 1970-01-01.
        write_offset(-11'sd720);
        send_epoch(32'd0);
        send_epoch(32'd43199);
        send_epoch(32'd43200);
        send_epoch(32'd43260);
        drain_pipeline();

        // Local time past 32 bits still lands in February 2106.
        write_offset(11'sd840);
        send_epoch(32'hFFFF_FFFF);
        send_epoch(32'hFFFF_0000);
        send_epoch(32'd4294915200);
        drain_pipeline();

        // Random phases: rotate the idle and stall mix and the offset each time.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            if (p == 5)
                write_offset(11'(int'($urandom_range(0, 1560)) - 720));
            else
                write_offset(phase_offsets[p]);
            // Fill the pipeline against a long output hold-off.
            if (p == 4)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_epoch(pick_epoch());
            drain_pipeline();
        end

        stall_pct = 0;
        drain_pipeline();

        $display("%0d timestamps through %0d offset settings, %0d results checked",
                 items_in, settings_used, sb.results_seen);
        $display("covered clamps both ways, leap days, range top, idle/stall mixes, hold-off");
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb_epoch_to_civil_datetime: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.outstanding());
            $display("tb_epoch_to_civil_datetime: errors");
        end
        $finish;
    end

endmodule
